### rtl/jtl_pkg.sv
// Package for the JSON token lexer: word types, token and error codes,
// byte classes and the keyword tables. Depends on nothing.

package jtl_pkg;

	localparam int STRING_INDEX_BITS = 16;
	localparam int MAX_DIGITS = 19;

	localparam int IQ_DEPTH = 2;
	localparam int IQ_AW = $clog2(IQ_DEPTH);
	localparam int RESQ_DEPTH = 4;
	localparam int RESQ_AW = $clog2(RESQ_DEPTH);

	localparam logic [3:0] TK_TRUE = 4'd6;
	localparam logic [3:0] TK_FALSE = 4'd7;
	localparam logic [3:0] TK_NULL = 4'd8;
	localparam logic [3:0] TK_STRBYTE = 4'd9;
	localparam logic [3:0] TK_STREND = 4'd10;
	localparam logic [3:0] TK_NUMBER = 4'd11;
	localparam logic [3:0] TK_ERROR = 4'd12;
	localparam logic [3:0] TK_END = 4'd13;

	localparam logic [1:0] ERR_KEYWORD = 2'd0;
	localparam logic [1:0] ERR_UNKNOWN = 2'd1;
	localparam logic [1:0] ERR_OPEN_STRING = 2'd2;
	localparam logic [1:0] ERR_CUT_KEYWORD = 2'd3;

	localparam logic [3:0] CL_PUNCT = 4'd0;
	localparam logic [3:0] CL_KEY_T = 4'd1;
	localparam logic [3:0] CL_KEY_F = 4'd2;
	localparam logic [3:0] CL_KEY_N = 4'd3;
	localparam logic [3:0] CL_QUOTE = 4'd4;
	localparam logic [3:0] CL_DIGIT = 4'd5;
	localparam logic [3:0] CL_DOT = 4'd6;
	localparam logic [3:0] CL_SPACE = 4'd7;
	localparam logic [3:0] CL_OTHER = 4'd8;

	localparam logic [1:0] KW_TRUE = 2'd0;
	localparam logic [1:0] KW_FALSE = 2'd1;
	localparam logic [1:0] KW_NULL = 2'd2;

	typedef struct packed {
		logic       func;
		logic [7:0] char_byte;
	} item_t;

	typedef struct packed {
		logic [3:0]  token_kind;
		logic [7:0]  token_byte;
		logic [15:0] string_index;
		logic [63:0] number_mantissa;
		logic [4:0]  fraction_digits;
		logic        number_overflow;
		logic [1:0]  error_code;
		logic        last;
	} token_t;

	typedef struct packed {
		logic       func;
		logic [7:0] char_byte;
		logic [3:0] cls;
		logic [2:0] punct;
	} cls_item_t;

	typedef struct packed {
		logic [1:0] n;
		token_t     t0;
		token_t     t1;
	} res_wr_t;

	function automatic logic [3:0] classify(input logic [7:0] c);
		logic [3:0] r;
		unique case (c) inside
			8'h7b, 8'h7d, 8'h5b, 8'h5d, 8'h3a, 8'h2c: r = CL_PUNCT;
			8'h74: r = CL_KEY_T;
			8'h66: r = CL_KEY_F;
			8'h6e: r = CL_KEY_N;
			8'h22: r = CL_QUOTE;
			[8'h30:8'h39]: r = CL_DIGIT;
			8'h2e: r = CL_DOT;
			8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d: r = CL_SPACE;
			default: r = CL_OTHER;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] punct_kind(input logic [7:0] c);
		logic [2:0] r;
		unique case (c)
			8'h7b: r = 3'd0;
			8'h7d: r = 3'd1;
			8'h5b: r = 3'd2;
			8'h5d: r = 3'd3;
			8'h3a: r = 3'd4;
			default: r = 3'd5;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [1:0] pos);
		logic [7:0] r;
		unique case ({sel, pos})
			{KW_TRUE, 2'd0}: r = 8'h72;
			{KW_TRUE, 2'd1}: r = 8'h75;
			{KW_TRUE, 2'd2}: r = 8'h65;
			{KW_FALSE, 2'd0}: r = 8'h61;
			{KW_FALSE, 2'd1}: r = 8'h6c;
			{KW_FALSE, 2'd2}: r = 8'h73;
			{KW_FALSE, 2'd3}: r = 8'h65;
			{KW_NULL, 2'd0}, {2'd3, 2'd0}: r = 8'h75;
			{KW_NULL, 2'd1}, {2'd3, 2'd1}: r = 8'h6c;
			{KW_NULL, 2'd2}, {2'd3, 2'd2}: r = 8'h6c;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] kw_len(input logic [1:0] sel);
		return (sel == KW_FALSE) ? 3'd4 : 3'd3;
	endfunction

	function automatic logic [3:0] kw_kind(input logic [1:0] sel);
		logic [3:0] r;
		unique case (sel)
			KW_TRUE: r = TK_TRUE;
			KW_FALSE: r = TK_FALSE;
			default: r = TK_NULL;
		endcase
		return r;
	endfunction

endpackage

### rtl/json_token_lexer_core.sv
// Top level of the JSON token lexer: front end, back end and result queue.
// Uses jtl_pkg, jtl_front, jtl_back and jtl_resq.

// One text byte or end word is accepted per clock cycle while full is low.
// Each word is classified and registered in the front end's two-entry queue,
// then the back end's state machine handles it, writing zero, one or two
// tokens into a four-entry result queue, where they are registered before
// they can be popped. The back end takes a word only when the result queue
// has room for two tokens, so the sustained rate is one word per cycle as
// long as tokens are popped at one per cycle; words that make two tokens (a
// number closed by punctuation or an unknown byte, and an end word after an
// open token) need two pops to drain.

module json_token_lexer_core import jtl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	output logic   full,
	input  item_t  item,
	output logic   empty,
	input  logic   pop,
	output token_t token
);

	logic      valid;
	cls_item_t citem;
	logic      take;
	logic      space;
	res_wr_t   wr;

	jtl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.valid  (valid),
		.citem  (citem),
		.take   (take)
	);

	jtl_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid),
		.citem  (citem),
		.take   (take),
		.space  (space),
		.wr     (wr)
	);

	jtl_resq u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.space  (space),
		.empty  (empty),
		.pop    (pop),
		.token  (token)
	);

endmodule

### rtl/jtl_front.sv
// Front end of the JSON token lexer: accepts input words, classifies each
// byte and holds the classified words in a short queue. Uses jtl_pkg.

module jtl_front import jtl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  item_t     item,
	output logic      valid,
	output cls_item_t citem,
	input  logic      take
);

	cls_item_t          q_q [IQ_DEPTH];
	logic [IQ_AW-1:0]   wp_q;
	logic [IQ_AW-1:0]   rp_q;
	logic [IQ_AW:0]     count_q;
	logic               wr;
	logic               rd;
	cls_item_t          entry;

	assign full = (count_q == (IQ_AW+1)'(IQ_DEPTH));
	assign valid = (count_q != '0);
	assign citem = q_q[rp_q];
	assign wr = push && !full;
	assign rd = take && valid;

	always_comb begin
		entry.func = item.func;
		entry.char_byte = item.char_byte;
		entry.cls = classify(item.char_byte);
		entry.punct = punct_kind(item.char_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			count_q <= count_q + (IQ_AW+1)'(wr) - (IQ_AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			q_q[wp_q] <= entry;
		end
	end

endmodule

### rtl/jtl_back.sv
// Back end of the JSON token lexer: the lexing state machine that turns
// classified words into up to two tokens each. Uses jtl_pkg.

module jtl_back import jtl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid,
	input  cls_item_t citem,
	output logic      take,
	input  logic      space,
	output res_wr_t   wr
);

	localparam logic [2:0] MODE_IDLE = 3'd0;
	localparam logic [2:0] MODE_KEY = 3'd1;
	localparam logic [2:0] MODE_STR = 3'd2;
	localparam logic [2:0] MODE_INT = 3'd3;
	localparam logic [2:0] MODE_FRAC = 3'd4;
	localparam logic [2:0] MODE_ERR = 3'd5;

	logic [2:0]                   mode_q, mode_d;
	logic [1:0]                   sel_q, sel_d;
	logic [1:0]                   pos_q, pos_d;
	logic [63:0]                  mant_q, mant_d;
	logic [4:0]                   dig_q, dig_d;
	logic [4:0]                   frac_q, frac_d;
	logic                         ovf_q, ovf_d;
	logic [STRING_INDEX_BITS-1:0] cnt_q, cnt_d;

	token_t     t0, t1, num_tok, idle_tok;
	logic [1:0] n;
	logic       idle_has;
	logic [2:0] idle_mode;
	logic [1:0] idle_sel;
	logic [7:0] c;

	assign take = valid && space;
	assign c = citem.char_byte;

	always_comb begin
		num_tok = '0;
		num_tok.token_kind = TK_NUMBER;
		num_tok.number_mantissa = mant_q;
		num_tok.fraction_digits = frac_q;
		num_tok.number_overflow = ovf_q;

		idle_tok = '0;
		idle_has = 1'b0;
		idle_mode = MODE_IDLE;
		idle_sel = sel_q;
		unique case (citem.cls)
			CL_PUNCT: begin
				idle_has = 1'b1;
				idle_tok.token_kind = {1'b0, citem.punct};
			end
			CL_KEY_T: begin
				idle_mode = MODE_KEY;
				idle_sel = KW_TRUE;
			end
			CL_KEY_F: begin
				idle_mode = MODE_KEY;
				idle_sel = KW_FALSE;
			end
			CL_KEY_N: begin
				idle_mode = MODE_KEY;
				idle_sel = KW_NULL;
			end
			CL_QUOTE: idle_mode = MODE_STR;
			CL_SPACE: idle_mode = MODE_IDLE;
			CL_DIGIT: idle_mode = MODE_INT;
			default: begin
				idle_has = 1'b1;
				idle_tok.token_kind = TK_ERROR;
				idle_tok.error_code = ERR_UNKNOWN;
				idle_mode = MODE_ERR;
			end
		endcase
	end

	always_comb begin
		mode_d = mode_q;
		sel_d = sel_q;
		pos_d = pos_q;
		mant_d = mant_q;
		dig_d = dig_q;
		frac_d = frac_q;
		ovf_d = ovf_q;
		cnt_d = cnt_q;
		t0 = '0;
		t1 = '0;
		n = 2'd0;
		if (take) begin
			if (citem.func) begin
				t1.token_kind = TK_END;
				n = 2'd2;
				if (mode_q == MODE_KEY) begin
					t0.token_kind = TK_ERROR;
					t0.error_code = ERR_CUT_KEYWORD;
				end else if (mode_q == MODE_STR) begin
					t0.token_kind = TK_ERROR;
					t0.error_code = ERR_OPEN_STRING;
				end else if (mode_q == MODE_INT || mode_q == MODE_FRAC) begin
					t0 = num_tok;
				end else begin
					t0 = t1;
					t1 = '0;
					n = 2'd1;
				end
				mode_d = MODE_IDLE;
				sel_d = '0;
				pos_d = '0;
				mant_d = '0;
				dig_d = '0;
				frac_d = '0;
				ovf_d = 1'b0;
				cnt_d = '0;
			end else begin
				unique case (mode_q)
					MODE_KEY: begin
						n = 2'd1;
						if (c != kw_char(sel_q, pos_q)) begin
							t0.token_kind = TK_ERROR;
							t0.error_code = ERR_KEYWORD;
							mode_d = MODE_ERR;
						end else if ({1'b0, pos_q} + 3'd1 >= kw_len(sel_q)) begin
							t0.token_kind = kw_kind(sel_q);
							mode_d = MODE_IDLE;
							pos_d = '0;
						end else begin
							n = 2'd0;
							pos_d = pos_q + 2'd1;
						end
					end
					MODE_STR: begin
						n = 2'd1;
						if (citem.cls == CL_QUOTE) begin
							t0.token_kind = TK_STREND;
							t0.string_index = 16'(cnt_q);
							cnt_d = cnt_q + 1'b1;
							mode_d = MODE_IDLE;
						end else begin
							t0.token_kind = TK_STRBYTE;
							t0.token_byte = c;
						end
					end
					MODE_INT, MODE_FRAC: begin
						if (citem.cls == CL_DIGIT) begin
							if (dig_q < 5'(MAX_DIGITS)) begin
								mant_d = (mant_q << 3) + (mant_q << 1) + 64'(c[3:0]);
								dig_d = dig_q + 5'd1;
								if (mode_q == MODE_FRAC) begin
									frac_d = frac_q + 5'd1;
								end
							end else begin
								ovf_d = 1'b1;
								if (mode_q == MODE_INT) begin
									mant_d = '1;
								end
							end
						end else if (citem.cls == CL_DOT && mode_q == MODE_INT) begin
							mode_d = MODE_FRAC;
						end else begin
							t0 = num_tok;
							t1 = idle_tok;
							n = idle_has ? 2'd2 : 2'd1;
							mant_d = '0;
							dig_d = '0;
							frac_d = '0;
							ovf_d = 1'b0;
							mode_d = idle_mode;
							sel_d = idle_sel;
							pos_d = '0;
						end
					end
					MODE_IDLE: begin
						t0 = idle_tok;
						n = idle_has ? 2'd1 : 2'd0;
						mode_d = idle_mode;
						sel_d = idle_sel;
						pos_d = '0;
						if (citem.cls == CL_DIGIT) begin
							mant_d = 64'(c[3:0]);
							dig_d = 5'd1;
							frac_d = '0;
							ovf_d = 1'b0;
						end
					end
					default: mode_d = mode_q;
				endcase
			end
		end
		if (n == 2'd1) begin
			t0.last = 1'b1;
		end
		if (n == 2'd2) begin
			t1.last = 1'b1;
		end
	end

	assign wr.n = n;
	assign wr.t0 = t0;
	assign wr.t1 = t1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			sel_q <= '0;
			pos_q <= '0;
			mant_q <= '0;
			dig_q <= '0;
			frac_q <= '0;
			ovf_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			mode_q <= mode_d;
			sel_q <= sel_d;
			pos_q <= pos_d;
			mant_q <= mant_d;
			dig_q <= dig_d;
			frac_q <= frac_d;
			ovf_q <= ovf_d;
			cnt_q <= cnt_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		take && citem.func |=> mode_q == MODE_IDLE && cnt_q == '0)
		else $error("End word did not return the lexer to its start state.");

	assert property (@(posedge clk) disable iff (!arst_n)
		take && citem.func |-> wr.n != 2'd0)
		else $error("End word produced no token.");

	assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_ERR && take && !citem.func |-> wr.n == 2'd0)
		else $error("Token produced while in error mode.");

endmodule

### rtl/jtl_resq.sv
// Result queue of the JSON token lexer: takes up to two tokens a cycle from
// the back end and hands out one token a cycle on pop. Uses jtl_pkg.

module jtl_resq import jtl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  res_wr_t wr,
	output logic    space,
	output logic    empty,
	input  logic    pop,
	output token_t  token
);

	token_t             q_q [RESQ_DEPTH];
	logic [RESQ_AW-1:0] wp_q;
	logic [RESQ_AW-1:0] rp_q;
	logic [RESQ_AW:0]   count_q;
	logic               rd;

	assign empty = (count_q == '0);
	assign space = (count_q <= (RESQ_AW+1)'(RESQ_DEPTH - 2));
	assign token = q_q[rp_q];
	assign rd = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count_q <= '0;
		end else begin
			wp_q <= wp_q + RESQ_AW'(wr.n);
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			count_q <= count_q + (RESQ_AW+1)'(wr.n) - (RESQ_AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr.n != 2'd0) begin
			q_q[wp_q] <= wr.t0;
		end
		if (wr.n == 2'd2) begin
			q_q[wp_q + 1'b1] <= wr.t1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (RESQ_AW+1)'(RESQ_DEPTH))
		else $error("Result queue count out of range.");

	assert property (@(posedge clk) disable iff (!arst_n)
		wr.n != 2'd0 |-> count_q <= (RESQ_AW+1)'(RESQ_DEPTH - 2))
		else $error("Tokens written without room for two.");

	assert property (@(posedge clk) disable iff (!arst_n)
		rd && wr.n == 2'd0 |=> count_q == $past(count_q) - 1'b1)
		else $error("Pop did not free a queue entry.");

endmodule
